[sv/idrm_pkg.sv]
package idrm_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int NICK_LIMIT_DEF    = 4096;
	localparam int KEY_W             = 31;
	localparam int NICK_W            = 12;
	localparam int OP_W              = 2;
	localparam int STAT_W            = 3;
	localparam int S_DATA_W          = 64;
	localparam int M_DATA_W          = 16;
	localparam int QUEUE_DEPTH       = 2;

	// operation codes on the input side
	localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_ACK   = 2'd2;

	typedef enum logic [1:0] {
		K_MAP,
		K_CLEAR,
		K_ACK,
		K_NONE
	} cmd_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_FOUND = 3'd0,
		ST_ALLOC = 3'd1,
		ST_REKEY = 3'd2,
		ST_MISS  = 3'd3,
		ST_FULL  = 3'd4,
		ST_DONE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_WR_HIT,
		S_CLEAR,
		S_RESP
	} eng_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [KEY_W-1:0]   ticket;
		logic [KEY_W-1:0]   repl_ticket;
		logic               has_new;
		logic               same_key;
	} cmd_t;

	typedef struct packed {
		logic               vld;
		logic [KEY_W-1:0]   key;
		logic [NICK_W-1:0]  nick;
	} entry_t;

endpackage

[sv/idrm_front.sv]
module idrm_front (
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [idrm_pkg::S_DATA_W-1:0]        s_tdata,  // ticket[30:0], repl_ticket[61:31], zero
	input  logic [idrm_pkg::OP_W-1:0]            s_tuser,  // operation[1:0]
	input  logic                                 q_full,
	input  logic                                 eng_busy_init,
	output logic                                 q_push,
	output idrm_pkg::cmd_t                       q_data
);

	logic [idrm_pkg::KEY_W-1:0] ticket;
	logic [idrm_pkg::KEY_W-1:0] repl_ticket;

	assign ticket      = s_tdata[idrm_pkg::KEY_W-1:0];
	assign repl_ticket = s_tdata[2*idrm_pkg::KEY_W-1:idrm_pkg::KEY_W];

	// nothing enters while the table is being swept after reset
	assign s_tready = !q_full && !eng_busy_init;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_data.ticket      = ticket;
		q_data.repl_ticket = repl_ticket;
		q_data.has_new     = (repl_ticket != '0);
		q_data.same_key    = (repl_ticket == ticket);
		case (s_tuser)
			idrm_pkg::OP_MAP:   q_data.kind = idrm_pkg::K_MAP;
			idrm_pkg::OP_CLEAR: q_data.kind = idrm_pkg::K_CLEAR;
			idrm_pkg::OP_ACK:   q_data.kind = idrm_pkg::K_ACK;
			default:            q_data.kind = idrm_pkg::K_NONE;
		endcase
	end

endmodule

[sv/idrm_queue.sv]
module idrm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  idrm_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output idrm_pkg::cmd_t  pop_data
);

	localparam int DEPTH = idrm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	idrm_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign valid    = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/idrm_engine.sv]
module idrm_engine #(
	parameter int TABLE_ENTRIES  = idrm_pkg::TABLE_ENTRIES_DEF,
	parameter int NICKNAME_LIMIT = idrm_pkg::NICK_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cq_valid,
	input  idrm_pkg::cmd_t                    cq_data,
	output logic                              cq_pop,
	output logic                              busy_init,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [idrm_pkg::M_DATA_W-1:0]     m_tdata,
	output logic [idrm_pkg::STAT_W-1:0]       m_tuser
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(NICKNAME_LIMIT);
	localparam int NW    = idrm_pkg::NICK_W;
	localparam int PAD_W = idrm_pkg::M_DATA_W - NW - 1;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W:0]   LIMIT_EXT = (CNT_W + 1)'(NICKNAME_LIMIT);

	idrm_pkg::eng_state_t state_q, state_d;
	idrm_pkg::cmd_t       cmd_q;
	idrm_pkg::entry_t     mem [TABLE_ENTRIES];

	logic [IDX_W-1:0]     idx_q;
	logic                 idx_last;

	// read stage
	idrm_pkg::entry_t     rd_s1;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	// scan results
	logic                 hit_vld_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [NW-1:0]        hit_nick_q;
	logic                 oth_vld_q;
	logic [IDX_W-1:0]     oth_idx_q;
	logic                 free_vld_q;
	logic [IDX_W-1:0]     free_idx_q;

	logic [CNT_W-1:0]     last_q;
	logic                 upd_q;
	logic [CNT_W:0]       next_wide;
	logic [CNT_W-1:0]     next_cnt;
	logic [NW-1:0]        next_nick;

	logic [NW-1:0]        res_nick_q;
	idrm_pkg::status_t    res_status_q;

	logic                 out_vld_q;
	logic [NW-1:0]        out_nick_q;
	idrm_pkg::status_t    out_status_q;
	logic                 out_upd_q;
	logic                 out_free;

	// memory port controls
	logic                 rd_en;
	logic                 we;
	logic [IDX_W-1:0]     wa;
	idrm_pkg::entry_t     wd;
	logic                 load_out;

	logic                 rekey_move;
	logic                 alloc_go;

	assign idx_last   = (idx_q == LAST_IDX);
	assign out_free   = !out_vld_q || m_tready;
	assign next_wide  = {1'b0, last_q} + 1'b1;
	assign next_cnt   = (next_wide >= LIMIT_EXT) ? CNT_W'(1) : next_wide[CNT_W-1:0];
	assign next_nick  = NW'(next_cnt);
	assign rekey_move = hit_vld_q && cmd_q.has_new && !cmd_q.same_key;
	assign alloc_go   = !hit_vld_q && !cmd_q.has_new && free_vld_q;

	assign busy_init = (state_q == idrm_pkg::S_INIT);
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {PAD_W'(0), out_upd_q, out_nick_q};
	assign m_tuser   = out_status_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			idrm_pkg::S_INIT: begin
				if (idx_last) state_d = idrm_pkg::S_IDLE;
			end
			idrm_pkg::S_IDLE: begin
				if (cq_valid) begin
					case (cq_data.kind)
						idrm_pkg::K_MAP:   state_d = idrm_pkg::S_SCAN;
						idrm_pkg::K_CLEAR: state_d = idrm_pkg::S_CLEAR;
						default:           state_d = idrm_pkg::S_RESP;
					endcase
				end
			end
			idrm_pkg::S_SCAN: begin
				if (idx_last) state_d = idrm_pkg::S_DRAIN;
			end
			idrm_pkg::S_DRAIN:  state_d = idrm_pkg::S_DECIDE;
			idrm_pkg::S_DECIDE: begin
				state_d = (rekey_move && oth_vld_q) ? idrm_pkg::S_WR_HIT : idrm_pkg::S_RESP;
			end
			idrm_pkg::S_WR_HIT: state_d = idrm_pkg::S_RESP;
			idrm_pkg::S_CLEAR: begin
				if (idx_last) state_d = idrm_pkg::S_RESP;
			end
			idrm_pkg::S_RESP: begin
				if (out_free) state_d = idrm_pkg::S_IDLE;
			end
			default: state_d = idrm_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cq_pop   = 1'b0;
		rd_en    = 1'b0;
		we       = 1'b0;
		wa       = idx_q;
		wd       = '0;
		load_out = 1'b0;
		case (state_q)
			idrm_pkg::S_INIT, idrm_pkg::S_CLEAR: begin
				we = 1'b1;
			end
			idrm_pkg::S_IDLE: begin
				cq_pop = cq_valid;
			end
			idrm_pkg::S_SCAN: begin
				rd_en = 1'b1;
			end
			idrm_pkg::S_DECIDE: begin
				if (rekey_move) begin
					we = 1'b1;
					if (oth_vld_q) begin
						// drop the entry that already holds the new key first
						wa = oth_idx_q;
					end else begin
						wa = hit_idx_q;
						wd = '{vld: 1'b1, key: cmd_q.repl_ticket, nick: hit_nick_q};
					end
				end else if (alloc_go) begin
					we = 1'b1;
					wa = free_idx_q;
					wd = '{vld: 1'b1, key: cmd_q.ticket, nick: next_nick};
				end
			end
			idrm_pkg::S_WR_HIT: begin
				we = 1'b1;
				wa = hit_idx_q;
				wd = '{vld: 1'b1, key: cmd_q.repl_ticket, nick: hit_nick_q};
			end
			idrm_pkg::S_RESP: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[idx_q];
		end
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= idrm_pkg::S_INIT;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			hit_vld_q    <= 1'b0;
			oth_vld_q    <= 1'b0;
			free_vld_q   <= 1'b0;
			last_q       <= '0;
			upd_q        <= 1'b0;
			out_vld_q    <= 1'b0;
			res_status_q <= idrm_pkg::ST_DONE;
			out_status_q <= idrm_pkg::ST_DONE;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;

			if (state_q == idrm_pkg::S_INIT || state_q == idrm_pkg::S_SCAN ||
			    state_q == idrm_pkg::S_CLEAR) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end

			if (cq_pop) begin
				hit_vld_q    <= 1'b0;
				oth_vld_q    <= 1'b0;
				free_vld_q   <= 1'b0;
				res_status_q <= idrm_pkg::ST_DONE;
				case (cq_data.kind)
					idrm_pkg::K_CLEAR: last_q <= '0;
					idrm_pkg::K_ACK:   upd_q  <= 1'b0;
					default: ;
				endcase
			end else if (rd_vld_s1) begin
				if (!hit_vld_q && rd_s1.vld && rd_s1.key == cmd_q.ticket) begin
					hit_vld_q <= 1'b1;
				end
				if (!oth_vld_q && rd_s1.vld && rd_s1.key == cmd_q.repl_ticket &&
				    cmd_q.has_new && !cmd_q.same_key) begin
					oth_vld_q <= 1'b1;
				end
				if (!free_vld_q && !rd_s1.vld) begin
					free_vld_q <= 1'b1;
				end
			end

			if (state_q == idrm_pkg::S_DECIDE) begin
				if (hit_vld_q) begin
					if (cmd_q.has_new) begin
						res_status_q <= idrm_pkg::ST_REKEY;
						upd_q        <= 1'b1;
					end else begin
						res_status_q <= idrm_pkg::ST_FOUND;
					end
				end else if (cmd_q.has_new) begin
					res_status_q <= idrm_pkg::ST_MISS;
				end else if (!free_vld_q) begin
					res_status_q <= idrm_pkg::ST_FULL;
				end else begin
					res_status_q <= idrm_pkg::ST_ALLOC;
					last_q       <= next_cnt;
					upd_q        <= 1'b1;
				end
			end

			if (load_out) begin
				out_vld_q    <= 1'b1;
				out_status_q <= res_status_q;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload of the scan and the result
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (rd_vld_s1 && !cq_pop) begin
			if (!hit_vld_q && rd_s1.vld && rd_s1.key == cmd_q.ticket) begin
				hit_idx_q  <= rd_idx_s1;
				hit_nick_q <= rd_s1.nick;
			end
			if (!oth_vld_q && rd_s1.vld && rd_s1.key == cmd_q.repl_ticket) begin
				oth_idx_q <= rd_idx_s1;
			end
			if (!free_vld_q && !rd_s1.vld) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (cq_pop) begin
			cmd_q      <= cq_data;
			res_nick_q <= '0;
		end else if (state_q == idrm_pkg::S_DECIDE) begin
			if (hit_vld_q) begin
				res_nick_q <= hit_nick_q;
			end else if (alloc_go) begin
				res_nick_q <= next_nick;
			end else begin
				res_nick_q <= '0;
			end
		end
		if (load_out) begin
			out_nick_q <= res_nick_q;
			out_upd_q  <= upd_q;
		end
	end

	a_pop_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> (state_q == idrm_pkg::S_IDLE && cq_valid))
		else $error("command taken outside idle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_vld_q || m_tready))
		else $error("result register overwritten");

	a_hit_other_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_vld_q && oth_vld_q) |-> (hit_idx_q != oth_idx_q))
		else $error("rekey target and dropped entry coincide");

	a_alloc_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idrm_pkg::S_DECIDE && alloc_go) |=> (last_q != '0))
		else $error("allocator produced zero");

	a_no_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en || rd_vld_s1) |-> !we)
		else $error("table written during scan");

endmodule

[sv/id_remap_table_with_allocator_unit.sv]
// channel | dir | fields
// s_*     | in  | tuser: operation[1:0]; tdata: ticket[30:0], repl_ticket[61:31]
// m_*     | out | tuser: status[2:0]; tdata: nickname[11:0], table_updated[12]
//
// a map request scans the whole table and then decides; a rekey that also drops
// another entry writes twice; the scan reads the single-port table one entry per cycle
// clear writes every entry; ack and unused codes go straight to the response
// after reset the table is swept with s_tready low
// a two-deep command queue takes up to two transfers while the engine is busy
// one result register; a stalled m side holds the next result at its end
module id_remap_table_with_allocator_unit #(
	parameter int TABLE_ENTRIES  = idrm_pkg::TABLE_ENTRIES_DEF,
	parameter int NICKNAME_LIMIT = idrm_pkg::NICK_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [idrm_pkg::S_DATA_W-1:0]     s_tdata,  // ticket[30:0], repl_ticket[61:31], zero
	input  logic [idrm_pkg::OP_W-1:0]         s_tuser,  // operation[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [idrm_pkg::M_DATA_W-1:0]     m_tdata,  // nickname[11:0], table_updated[12], zero
	output logic [idrm_pkg::STAT_W-1:0]       m_tuser   // status[2:0]
);

	idrm_pkg::cmd_t push_data;
	idrm_pkg::cmd_t pop_data;
	logic           push;
	logic           full;
	logic           pop;
	logic           q_valid;
	logic           busy_init;

	idrm_front u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.q_full        (full),
		.eng_busy_init (busy_init),
		.q_push        (push),
		.q_data        (push_data)
	);

	idrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	idrm_engine #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.NICKNAME_LIMIT (NICKNAME_LIMIT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_valid  (q_valid),
		.cq_data   (pop_data),
		.cq_pop    (pop),
		.busy_init (busy_init),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
